[rtl/core/tts_pkg.sv]
// Shared types and constants of the tilt-rotor transition sequencer.
package tts_pkg;

   typedef enum logic [2:0] {
      PH_MC   = 3'd0,
      PH_P1   = 3'd1,
      PH_P2   = 3'd2,
      PH_FW   = 3'd3,
      PH_BACK = 3'd4
   } phase_type;

   localparam logic [1:0] REAR_ENABLED  = 2'd0;
   localparam logic [1:0] REAR_DISABLED = 2'd1;
   localparam logic [1:0] REAR_IDLE     = 2'd2;

   localparam logic [1:0] MODE_ROTARY = 2'd0;
   localparam logic [1:0] MODE_TO_FW  = 2'd1;
   localparam logic [1:0] MODE_FW     = 2'd2;
   localparam logic [1:0] MODE_TO_RC  = 2'd3;

   localparam logic [2:0] CSR_P1_DUR    = 3'd0;
   localparam logic [2:0] CSR_P2_DUR    = 3'd1;
   localparam logic [2:0] CSR_BACK_DUR  = 3'd2;
   localparam logic [2:0] CSR_TILT_MC   = 3'd3;
   localparam logic [2:0] CSR_TILT_TR   = 3'd4;
   localparam logic [2:0] CSR_TILT_FW   = 3'd5;
   localparam logic [2:0] CSR_SPD_SW    = 3'd6;
   localparam logic [2:0] CSR_SPD_BLEND = 3'd7;

   localparam int QUO_W = 49;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start_div;
      logic apply;
   } cmd_type;

   // Status back to the controller.
   typedef struct packed {
      logic div_done;
   } status_type;

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      if (v > 20'sd32767) return 16'sh7fff;
      if (v < -20'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

endpackage

[rtl/core/tiltrotor_transition_sequencer_core.sv]
// Top level of the tilt-rotor transition sequencer.
// One transaction is one control tick. After acceptance the operands are latched, a
// 17-step shift-add multiply forms the ramp dividend and a restoring divider gives one
// of 49 quotient bits a cycle (it gives none when the duration of the ramp in use is
// zero); then the result is loaded into the output register. One tick is in work at a
// time and the input is stalled from acceptance until the result is loaded, so the next
// transaction is accepted in the cycle after the load at the earliest, and a new tick is
// not taken before the last one is through. If the previous result still waits in the
// output register, the update waits for it and the input stays stalled.
module tiltrotor_transition_sequencer_core
   import tts_pkg::*;
#(
   parameter int PITCH_TRIM    = 0,
   parameter int YAW_OFF_SPEED = 700
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_want_fixed_wing,
   input  logic               req_ground_ok,
   input  logic [15:0]        req_airspeed_cms,
   input  logic [31:0]        req_now_us,
   input  logic signed [15:0] req_rotor_roll,
   input  logic signed [15:0] req_rotor_pitch,
   input  logic signed [15:0] req_rotor_yaw,
   input  logic signed [15:0] req_rotor_throttle,
   input  logic signed [15:0] req_wing_roll,
   input  logic signed [15:0] req_wing_pitch,
   input  logic signed [15:0] req_wing_yaw,
   input  logic signed [15:0] req_wing_throttle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_phase,
   output logic [1:0]         rsp_simple_mode,
   output logic signed [15:0] rsp_tilt_out,
   output logic signed [15:0] rsp_motor_roll,
   output logic signed [15:0] rsp_motor_pitch,
   output logic signed [15:0] rsp_motor_yaw,
   output logic signed [15:0] rsp_motor_throttle,
   output logic signed [15:0] rsp_surface_roll,
   output logic signed [15:0] rsp_surface_pitch,
   output logic signed [15:0] rsp_surface_yaw,
   output logic [1:0]         rsp_rear_motors
);

   cmd_type    cmd;
   status_type status;

   tts_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd)
   );

   tts_dp #(.PITCH_TRIM(PITCH_TRIM), .YAW_OFF_SPEED(YAW_OFF_SPEED)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_want_fixed_wing(req_want_fixed_wing), .req_ground_ok(req_ground_ok),
      .req_airspeed_cms(req_airspeed_cms), .req_now_us(req_now_us),
      .req_rotor_roll(req_rotor_roll), .req_rotor_pitch(req_rotor_pitch),
      .req_rotor_yaw(req_rotor_yaw), .req_rotor_throttle(req_rotor_throttle),
      .req_wing_roll(req_wing_roll), .req_wing_pitch(req_wing_pitch),
      .req_wing_yaw(req_wing_yaw), .req_wing_throttle(req_wing_throttle),
      .rsp_phase(rsp_phase), .rsp_simple_mode(rsp_simple_mode),
      .rsp_tilt_out(rsp_tilt_out), .rsp_motor_roll(rsp_motor_roll),
      .rsp_motor_pitch(rsp_motor_pitch), .rsp_motor_yaw(rsp_motor_yaw),
      .rsp_motor_throttle(rsp_motor_throttle), .rsp_surface_roll(rsp_surface_roll),
      .rsp_surface_pitch(rsp_surface_pitch), .rsp_surface_yaw(rsp_surface_yaw),
      .rsp_rear_motors(rsp_rear_motors)
   );

endmodule

[rtl/core/tts_ctrl.sv]
// Controller of the tilt-rotor transition sequencer.
module tts_ctrl
   import tts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_APPLY
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Command decode: a transaction is captured whenever the controller is idle, and the
   // update waits until the output register is free or being emptied.
   always_comb begin
      cmd.start_div = (state_ff == S_IDLE) && req_valid;
      cmd.apply     = (state_ff == S_APPLY) && !(rsp_valid_ff && rsp_stall);
   end

   // Sequencing of one transaction: divide, then update state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.apply || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.start_div) state_ff <= S_DIV;
            end
            S_DIV: begin
               if (status.div_done) state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (cmd.apply) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/core/tts_dp.sv]
// Datapath of the tilt-rotor transition sequencer: phase logic, ramp divider and mixer.
module tts_dp
   import tts_pkg::*;
#(
   parameter int PITCH_TRIM    = 0,
   parameter int YAW_OFF_SPEED = 700
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data,
   input  logic               req_want_fixed_wing,
   input  logic               req_ground_ok,
   input  logic [15:0]        req_airspeed_cms,
   input  logic [31:0]        req_now_us,
   input  logic signed [15:0] req_rotor_roll,
   input  logic signed [15:0] req_rotor_pitch,
   input  logic signed [15:0] req_rotor_yaw,
   input  logic signed [15:0] req_rotor_throttle,
   input  logic signed [15:0] req_wing_roll,
   input  logic signed [15:0] req_wing_pitch,
   input  logic signed [15:0] req_wing_yaw,
   input  logic signed [15:0] req_wing_throttle,
   output logic [2:0]         rsp_phase,
   output logic [1:0]         rsp_simple_mode,
   output logic signed [15:0] rsp_tilt_out,
   output logic signed [15:0] rsp_motor_roll,
   output logic signed [15:0] rsp_motor_pitch,
   output logic signed [15:0] rsp_motor_yaw,
   output logic signed [15:0] rsp_motor_throttle,
   output logic signed [15:0] rsp_surface_roll,
   output logic signed [15:0] rsp_surface_pitch,
   output logic signed [15:0] rsp_surface_yaw,
   output logic [1:0]         rsp_rear_motors
);

   // Configuration registers.
   logic [22:0]        p1_dur_ff;
   logic [23:0]        p2_dur_ff;
   logic [22:0]        back_dur_ff;
   logic signed [15:0] t_mc_ff, t_tr_ff, t_fw_ff;
   logic [15:0]        spd_sw_ff, spd_blend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_dur_ff    <= 23'd1000000;
         p2_dur_ff    <= 24'd500000;
         back_dur_ff  <= 23'd2000000;
         t_mc_ff      <= 16'sd0;
         t_tr_ff      <= 16'sd13107;
         t_fw_ff      <= 16'sd32767;
         spd_sw_ff    <= 16'd1400;
         spd_blend_ff <= 16'd800;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_P1_DUR:    p1_dur_ff    <= csr_data[22:0];
            CSR_P2_DUR:    p2_dur_ff    <= csr_data;
            CSR_BACK_DUR:  back_dur_ff  <= csr_data[22:0];
            CSR_TILT_MC:   t_mc_ff      <= csr_data[15:0];
            CSR_TILT_TR:   t_tr_ff      <= csr_data[15:0];
            CSR_TILT_FW:   t_fw_ff      <= csr_data[15:0];
            CSR_SPD_SW:    spd_sw_ff    <= csr_data[15:0];
            CSR_SPD_BLEND: spd_blend_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Sequencer state.
   phase_type          phase_ff;
   logic [31:0]        start_ff;
   logic signed [15:0] tilt_ff;
   logic               rw_ff, pw_ff, yw_ff;
   logic [1:0]         rear_ff;

   // Captured transaction.
   logic        want_ff, gnd_ff;
   logic [15:0] spd_ff;
   logic [31:0] now_ff;
   logic signed [15:0] r_roll_ff, r_pitch_ff, r_yaw_ff, r_thr_ff;
   logic signed [15:0] w_roll_ff, w_pitch_ff, w_yaw_ff, w_thr_ff;

   // Phase transition, computed from the captured item and current state.
   phase_type   ph_raw, ph_nx;
   logic        new_start;
   logic        tilt_jump_fw;
   logic [16:0] sw_eff;
   logic [16:0] blend_p;

   always_comb begin
      ph_raw  = (phase_ff > PH_BACK) ? PH_MC : phase_ff;
      ph_nx   = ph_raw;
      new_start    = 1'b0;
      tilt_jump_fw = 1'b0;
      blend_p = {1'b0, spd_blend_ff} + 17'd100;
      sw_eff  = ({1'b0, spd_sw_ff} < blend_p) ? blend_p : {1'b0, spd_sw_ff};
      if (!want_ff) begin
         unique case (ph_raw)
            PH_FW: begin
               ph_nx = PH_BACK;
               new_start = 1'b1;
            end
            PH_P1, PH_P2: ph_nx = PH_MC;
            PH_BACK: if (tilt_ff <= t_mc_ff) ph_nx = PH_MC;
            default: ;
         endcase
      end else begin
         unique case (ph_raw)
            PH_MC: begin
               ph_nx = PH_P1;
               new_start = 1'b1;
            end
            PH_P1: if (({1'b0, spd_ff} >= sw_eff) || gnd_ff) begin
               ph_nx = PH_P2;
               new_start = 1'b1;
            end
            PH_P2: if (tilt_ff >= t_fw_ff) begin
               ph_nx = PH_FW;
               tilt_jump_fw = 1'b1;
            end
            PH_BACK: ph_nx = PH_FW;
            default: ;
         endcase
      end
   end

   logic signed [15:0] tilt_mid;
   logic [31:0]        start_mid;
   logic [31:0]        elapsed;

   assign tilt_mid  = tilt_jump_fw ? t_fw_ff : tilt_ff;
   assign start_mid = new_start ? now_ff : start_ff;
   assign elapsed   = now_ff - start_mid;

   // Ramp operands per phase.
   logic signed [16:0] diff;
   logic [16:0]        ad;
   logic [23:0]        dur;
   always_comb begin
      case (ph_nx)
         PH_P1: begin
            diff = 17'(t_tr_ff) - 17'(t_mc_ff);
            dur  = {1'b0, p1_dur_ff};
         end
         PH_P2: begin
            diff = 17'(t_fw_ff) - 17'(t_tr_ff);
            dur  = p2_dur_ff;
         end
         default: begin
            diff = 17'(t_fw_ff) - 17'(t_mc_ff);
            dur  = {1'b0, back_dur_ff};
         end
      endcase
      ad = diff[16] ? 17'(-diff) : 17'(diff);
   end

   // Restoring divider, one quotient bit per cycle. The dividend ad*elapsed
   // is formed as a sum of shifted elapsed terms, one bit of ad per cycle.
   logic [QUO_W-1:0] prod_ff;
   logic [16:0]      ad_ff;
   logic [4:0]       mcnt_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [24:0]      rem_ff;
   logic [5:0]       dcnt_ff;
   logic             mul_ff, div_ff, done_ff;
   logic [23:0]      dur_ff;
   logic [24:0]      rem_sh;

   assign rem_sh = {rem_ff[23:0], quo_ff[QUO_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         div_ff  <= 1'b0;
         done_ff <= 1'b0;
         mcnt_ff <= 5'd30;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start_div) begin
            mul_ff  <= 1'b0;
            div_ff  <= 1'b0;
         end else if (!mul_ff && !div_ff && !done_ff && mcnt_ff == 5'd31) begin
            // First cycle after capture: latch operands.
            prod_ff <= '0;
            ad_ff   <= ad;
            dur_ff  <= dur;
            mcnt_ff <= 5'd0;
            mul_ff  <= 1'b1;
         end else if (mul_ff) begin
            if (ad_ff[0]) prod_ff <= prod_ff + (QUO_W'(elapsed) << mcnt_ff);
            ad_ff <= ad_ff >> 1;
            if (mcnt_ff == 5'd16) begin
               mul_ff  <= 1'b0;
               div_ff  <= 1'b1;
               dcnt_ff <= 6'd0;
               rem_ff  <= '0;
            end else begin
               mcnt_ff <= mcnt_ff + 5'd1;
            end
         end else if (div_ff) begin
            if (dur_ff == 24'd0) begin
               div_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               if (dcnt_ff == 6'd0) quo_ff <= prod_ff;
               else begin
                  if (rem_sh >= {1'b0, dur_ff}) begin
                     rem_ff <= rem_sh - {1'b0, dur_ff};
                     quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
                  end
               end
               if (dcnt_ff == 6'(QUO_W)) begin
                  div_ff  <= 1'b0;
                  done_ff <= 1'b1;
               end
               dcnt_ff <= dcnt_ff + 6'd1;
            end
         end
         if (cmd.start_div) mcnt_ff <= 5'd31;
         else if (done_ff) mcnt_ff <= 5'd30;
      end
   end

   assign status.div_done = done_ff;

   // Ramp term, saturated to fit the sum width; a zero duration gives the full span.
   logic [16:0] ad_keep_ff;
   always_ff @(posedge clock) begin
      if (cmd.start_div) ad_keep_ff <= '0;
      else if (!mul_ff && !div_ff && !done_ff && mcnt_ff == 5'd31) ad_keep_ff <= ad;
   end
   logic [QUO_W-1:0] term_src;
   assign term_src = (dur_ff == 24'd0) ? QUO_W'(ad_keep_ff) : quo_ff;
   logic [17:0] term_c;
   always_comb begin
      if (term_src > QUO_W'(18'h1ffff)) term_c = 18'h1ffff;
      else term_c = term_src[17:0];
   end

   // Per-phase state update.
   logic signed [15:0] tilt_nx;
   logic               rw_nx, pw_nx, yw_nx;
   logic [1:0]         rear_nx;
   logic signed [19:0] sum;
   always_comb begin
      tilt_nx = tilt_mid;
      rw_nx   = rw_ff;
      pw_nx   = pw_ff;
      yw_nx   = yw_ff;
      rear_nx = rear_ff;
      sum     = '0;
      unique case (ph_nx)
         PH_FW: begin
            rw_nx = 1'b0; pw_nx = 1'b0; yw_nx = 1'b0;
            tilt_nx = t_fw_ff;
            rear_nx = REAR_DISABLED;
         end
         PH_P1: begin
            rear_nx = REAR_ENABLED;
            sum = 20'(t_mc_ff) + 20'(signed'({2'b00, term_c}));
            if (tilt_mid <= t_tr_ff) tilt_nx = sat16(sum);
            rw_nx = (spd_ff >= spd_blend_ff) ? 1'b0 : 1'b1;
            yw_nx = (32'(spd_ff) > 32'(YAW_OFF_SPEED)) ? 1'b0 : 1'b1;
         end
         PH_P2: begin
            sum = 20'(t_tr_ff) + 20'(signed'({2'b00, term_c}));
            tilt_nx = sat16(sum);
            rw_nx = 1'b0;
         end
         PH_BACK: begin
            rear_nx = REAR_IDLE;
            sum = 20'(t_fw_ff) - 20'(signed'({2'b00, term_c}));
            if (tilt_mid > t_mc_ff) tilt_nx = sat16(sum);
            rw_nx = 1'b0;
         end
         default: begin
            rw_nx = 1'b1; pw_nx = 1'b1; yw_nx = 1'b1;
            tilt_nx = t_mc_ff;
            rear_nx = REAR_ENABLED;
         end
      endcase
   end

   // Capture of the input transaction and state commit.
   logic signed [15:0] ptrim;
   logic signed [16:0] neg_roll;
   logic signed [17:0] pitch_sum;
   assign ptrim     = 16'(PITCH_TRIM);
   assign neg_roll  = -17'(w_roll_ff);
   assign pitch_sum = 18'(w_pitch_ff) + 18'(ptrim);

   logic [2:0]         rsp_phase_ff;
   logic [1:0]         rsp_simple_mode_ff;
   logic signed [15:0] rsp_tilt_out_ff;
   logic signed [15:0] rsp_motor_roll_ff, rsp_motor_pitch_ff, rsp_motor_yaw_ff;
   logic signed [15:0] rsp_motor_throttle_ff;
   logic signed [15:0] rsp_surface_roll_ff, rsp_surface_pitch_ff, rsp_surface_yaw_ff;
   logic [1:0]         rsp_rear_motors_ff;

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         want_ff    <= req_want_fixed_wing;
         gnd_ff     <= req_ground_ok;
         spd_ff     <= req_airspeed_cms;
         now_ff     <= req_now_us;
         r_roll_ff  <= req_rotor_roll;
         r_pitch_ff <= req_rotor_pitch;
         r_yaw_ff   <= req_rotor_yaw;
         r_thr_ff   <= req_rotor_throttle;
         w_roll_ff  <= req_wing_roll;
         w_pitch_ff <= req_wing_pitch;
         w_yaw_ff   <= req_wing_yaw;
         w_thr_ff   <= req_wing_throttle;
      end
      if (cmd.apply) begin
         rsp_phase_ff          <= ph_nx;
         rsp_simple_mode_ff    <= (ph_nx == PH_MC) ? MODE_ROTARY :
                                  (ph_nx == PH_FW) ? MODE_FW :
                                  (ph_nx == PH_BACK) ? MODE_TO_RC : MODE_TO_FW;
         rsp_tilt_out_ff       <= tilt_nx;
         rsp_motor_roll_ff     <= rw_nx ? r_roll_ff : 16'sd0;
         rsp_motor_pitch_ff    <= pw_nx ? r_pitch_ff : 16'sd0;
         rsp_motor_yaw_ff      <= yw_nx ? r_yaw_ff : 16'sd0;
         rsp_motor_throttle_ff <= (ph_nx == PH_FW) ? w_thr_ff :
                                  (ph_nx == PH_BACK) ? 16'sd0 : r_thr_ff;
         rsp_surface_roll_ff   <= rw_nx ? 16'sd0 : sat16(20'(neg_roll));
         rsp_surface_pitch_ff  <= pw_nx ? 16'sd0 : sat16(20'(pitch_sum));
         rsp_surface_yaw_ff    <= yw_nx ? 16'sd0 : w_yaw_ff;
         rsp_rear_motors_ff    <= rear_nx;
      end
   end

   assign rsp_phase          = rsp_phase_ff;
   assign rsp_simple_mode    = rsp_simple_mode_ff;
   assign rsp_tilt_out       = rsp_tilt_out_ff;
   assign rsp_motor_roll     = rsp_motor_roll_ff;
   assign rsp_motor_pitch    = rsp_motor_pitch_ff;
   assign rsp_motor_yaw      = rsp_motor_yaw_ff;
   assign rsp_motor_throttle = rsp_motor_throttle_ff;
   assign rsp_surface_roll   = rsp_surface_roll_ff;
   assign rsp_surface_pitch  = rsp_surface_pitch_ff;
   assign rsp_surface_yaw    = rsp_surface_yaw_ff;
   assign rsp_rear_motors    = rsp_rear_motors_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MC;
         start_ff <= '0;
         tilt_ff  <= '0;
         rw_ff    <= 1'b1;
         pw_ff    <= 1'b1;
         yw_ff    <= 1'b1;
         rear_ff  <= REAR_ENABLED;
      end else if (cmd.apply) begin
         phase_ff <= ph_nx;
         start_ff <= start_mid;
         tilt_ff  <= tilt_nx;
         rw_ff    <= rw_nx;
         pw_ff    <= pw_nx;
         yw_ff    <= yw_nx;
         rear_ff  <= rear_nx;
      end
   end

endmodule

[verif/tiltrotor_transition_sequencer_core_test.sv]
// Self-checking testbench for the tilt-rotor transition sequencer core.
`timescale 1ns / 1ps

module tiltrotor_transition_sequencer_core_test
   import tts_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SECTION_ITEMS  = 170;
   localparam int PITCH_TRIM     = 0;
   localparam int YAW_OFF_SPEED  = 700;

   typedef struct packed {
      logic               want;
      logic               gnd;
      logic [15:0]        spd;
      logic [31:0]        now;
      logic signed [15:0] r_roll, r_pitch, r_yaw, r_thr;
      logic signed [15:0] w_roll, w_pitch, w_yaw, w_thr;
   } tick_type;

   typedef struct packed {
      logic [2:0]         phase;
      logic [1:0]         mode;
      logic signed [15:0] tilt;
      logic signed [15:0] m_roll, m_pitch, m_yaw, m_thr;
      logic signed [15:0] s_roll, s_pitch, s_yaw;
      logic [1:0]         rear;
   } mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   tick_type cur = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mix_type got;

   tiltrotor_transition_sequencer_core #(
      .PITCH_TRIM(PITCH_TRIM), .YAW_OFF_SPEED(YAW_OFF_SPEED)
   ) uut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_want_fixed_wing(cur.want), .req_ground_ok(cur.gnd),
      .req_airspeed_cms(cur.spd), .req_now_us(cur.now),
      .req_rotor_roll(cur.r_roll), .req_rotor_pitch(cur.r_pitch),
      .req_rotor_yaw(cur.r_yaw), .req_rotor_throttle(cur.r_thr),
      .req_wing_roll(cur.w_roll), .req_wing_pitch(cur.w_pitch),
      .req_wing_yaw(cur.w_yaw), .req_wing_throttle(cur.w_thr),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_phase(got.phase), .rsp_simple_mode(got.mode), .rsp_tilt_out(got.tilt),
      .rsp_motor_roll(got.m_roll), .rsp_motor_pitch(got.m_pitch),
      .rsp_motor_yaw(got.m_yaw), .rsp_motor_throttle(got.m_thr),
      .rsp_surface_roll(got.s_roll), .rsp_surface_pitch(got.s_pitch),
      .rsp_surface_yaw(got.s_yaw), .rsp_rear_motors(got.rear)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the registers and the sequencer state.
   logic [23:0] dur_p1 = 24'd1000000, dur_p2 = 24'd500000, dur_back = 24'd2000000;
   logic signed [15:0] tilt_mc = 16'sd0, tilt_tr = 16'sd13107, tilt_fw = 16'sd32767;
   logic [15:0] spd_switch = 16'd1400, spd_blend = 16'd800;
   phase_type st_phase = PH_MC;
   logic [31:0] st_start = '0;
   logic signed [15:0] st_tilt = '0;
   logic wt_roll = 1'b1, wt_pitch = 1'b1, wt_yaw = 1'b1;
   logic [1:0] st_rear = REAR_ENABLED;

   tick_type pending_ticks[$];
   mix_type expected_mixes[$];
   mix_type want_mix;
   int errors = 0;
   int send_idle = 25, recv_idle = 46;
   logic hold_off = 1'b0;
   logic req_taken = 1'b0;
   int sent_count = 0, recv_count = 0, predicted_count = 0;
   int idle_cycles = 0;
   logic [31:0] gen_now = 32'hfff0_0000;
   logic gen_want = 1'b0;

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic longint ramp_amount(longint a, longint b, longint dur,
                                          logic [31:0] el);
      longint d;
      d = b - a;
      if (d < 0) d = -d;
      if (dur == 0) return d;
      return (d * longint'(el)) / dur;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_P1_DUR:    dur_p1 = val & 24'h7fffff;
         CSR_P2_DUR:    dur_p2 = val;
         CSR_BACK_DUR:  dur_back = val & 24'h7fffff;
         CSR_TILT_MC:   tilt_mc = val[15:0];
         CSR_TILT_TR:   tilt_tr = val[15:0];
         CSR_TILT_FW:   tilt_fw = val[15:0];
         CSR_SPD_SW:    spd_switch = val[15:0];
         CSR_SPD_BLEND: spd_blend = val[15:0];
         default: ;
      endcase
   endtask

   // Advance the predicted state by one tick and queue the expected outputs.
   task automatic predict_tick(input tick_type t);
      int sw_eff;
      logic [31:0] el;
      mix_type m;
      sw_eff = (int'(spd_switch) < int'(spd_blend) + 100) ? int'(spd_blend) + 100
                                                         : int'(spd_switch);
      if (!t.want) begin
         if (st_phase == PH_FW) begin
            st_phase = PH_BACK;
            st_start = t.now;
         end else if (st_phase == PH_P1 || st_phase == PH_P2) st_phase = PH_MC;
         else if (st_phase == PH_BACK && st_tilt <= tilt_mc) st_phase = PH_MC;
      end else begin
         if (st_phase == PH_MC) begin
            st_phase = PH_P1;
            st_start = t.now;
         end else if (st_phase == PH_P1) begin
            if (int'(t.spd) >= sw_eff || t.gnd) begin
               st_phase = PH_P2;
               st_start = t.now;
            end
         end else if (st_phase == PH_P2) begin
            if (st_tilt >= tilt_fw) begin
               st_phase = PH_FW;
               st_tilt = tilt_fw;
            end
         end else if (st_phase == PH_BACK) st_phase = PH_FW;
      end
      el = t.now - st_start;
      case (st_phase)
         PH_FW: begin
            {wt_roll, wt_pitch, wt_yaw} = 3'b000;
            st_tilt = tilt_fw;
            st_rear = REAR_DISABLED;
         end
         PH_P1: begin
            st_rear = REAR_ENABLED;
            if (st_tilt <= tilt_tr)
               st_tilt = clip16(tilt_mc + ramp_amount(tilt_mc, tilt_tr, dur_p1, el));
            wt_roll = !(t.spd >= spd_blend);
            wt_yaw = !(int'(t.spd) > YAW_OFF_SPEED);
         end
         PH_P2: begin
            st_tilt = clip16(tilt_tr + ramp_amount(tilt_tr, tilt_fw, dur_p2, el));
            wt_roll = 1'b0;
         end
         PH_BACK: begin
            st_rear = REAR_IDLE;
            if (st_tilt > tilt_mc)
               st_tilt = clip16(tilt_fw - ramp_amount(tilt_mc, tilt_fw, dur_back, el));
            wt_roll = 1'b0;
         end
         default: begin
            {wt_roll, wt_pitch, wt_yaw} = 3'b111;
            st_tilt = tilt_mc;
            st_rear = REAR_ENABLED;
         end
      endcase
      m.phase = st_phase;
      case (st_phase)
         PH_MC:   m.mode = MODE_ROTARY;
         PH_FW:   m.mode = MODE_FW;
         PH_BACK: m.mode = MODE_TO_RC;
         default: m.mode = MODE_TO_FW;
      endcase
      m.tilt = st_tilt;
      m.m_roll = wt_roll ? t.r_roll : 16'sd0;
      m.m_pitch = wt_pitch ? t.r_pitch : 16'sd0;
      m.m_yaw = wt_yaw ? t.r_yaw : 16'sd0;
      m.m_thr = (st_phase == PH_FW) ? t.w_thr : (st_phase == PH_BACK) ? 16'sd0 : t.r_thr;
      m.s_roll = wt_roll ? 16'sd0 : clip16(-longint'(t.w_roll));
      m.s_pitch = wt_pitch ? 16'sd0 : clip16(longint'(t.w_pitch) + longint'(PITCH_TRIM));
      m.s_yaw = wt_yaw ? 16'sd0 : t.w_yaw;
      m.rear = st_rear;
      expected_mixes.push_back(m);
   endtask

   // Random control tick with advancing, wrapping time and a slowly changing request.
   task automatic gen_tick(output tick_type t);
      gen_now = gen_now + 32'($urandom_range(50000, 2000));
      if ($urandom_range(79) == 0) gen_want = !gen_want;
      t.want = gen_want;
      t.gnd = ($urandom_range(29) == 0);
      case ($urandom_range(19))
         0: t.spd = 16'hffff;
         1: t.spd = 16'd0;
         default: t.spd = 16'($urandom_range(3000));
      endcase
      t.now = gen_now;
      t.r_roll = 16'($urandom);
      t.r_pitch = 16'($urandom);
      t.r_yaw = 16'($urandom);
      t.r_thr = 16'($urandom);
      t.w_roll = ($urandom_range(15) == 0) ? 16'sh8000 : 16'($urandom);
      t.w_pitch = 16'($urandom);
      t.w_yaw = 16'($urandom);
      t.w_thr = 16'($urandom);
   endtask

   task automatic queue_items(input int count);
      tick_type t;
      for (int i = 0; i < count; i++) begin
         gen_tick(t);
         predict_tick(t);
         pending_ticks.push_back(t);
         predicted_count++;
      end
   endtask

   // The sender stays quiet until every expected result has come back.
   task automatic wait_drain();
      while (expected_mixes.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input mix_type exp_m,
                                  input mix_type got_m);
      errors++;
      $display("mismatch %s: expected %h, got %h at %0t", what, exp_m, got_m, $time);
   endtask

   // Driver: present queued transactions at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle) begin
            cur <= pending_ticks.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall, or a long hold-off when requested.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // Long receiver hold-off while the sender keeps offering transactions.
   initial begin
      wait (sent_count >= 60);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   // Monitor: note accepted inputs and check results at the rising edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) sent_count <= sent_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         recv_count <= recv_count + 1;
         if (expected_mixes.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
         end else begin
            want_mix = expected_mixes.pop_front();
            if (got !== want_mix) report_mismatch("result", want_mix, got);
         end
      end
   end

   // Watchdog on cycles in which nothing is accepted.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset register values; the sender idles less than the receiver.
      queue_items(SECTION_ITEMS);
      wait_drain();

      // Zero durations, out-of-order tilts and a blend speed near the top of its range.
      write_reg(CSR_P1_DUR, 24'd0);
      write_reg(CSR_P2_DUR, 24'd0);
      write_reg(CSR_BACK_DUR, 24'd0);
      write_reg(CSR_TILT_MC, 24'(-20000));
      write_reg(CSR_TILT_TR, 24'd25000);
      write_reg(CSR_TILT_FW, 24'(-32768));
      write_reg(CSR_SPD_SW, 24'd100);
      write_reg(CSR_SPD_BLEND, 24'd65500);
      send_idle = 46;
      recv_idle = 25;
      queue_items(SECTION_ITEMS);
      wait_drain();

      // Long ramps with a falling first stage, and no idling on either side.
      write_reg(CSR_P1_DUR, 24'd4000000);
      write_reg(CSR_P2_DUR, 24'd10000000);
      write_reg(CSR_BACK_DUR, 24'd5000000);
      write_reg(CSR_TILT_MC, 24'd1000);
      write_reg(CSR_TILT_TR, 24'(-5000));
      write_reg(CSR_TILT_FW, 24'd20000);
      write_reg(CSR_SPD_SW, 24'd2000);
      write_reg(CSR_SPD_BLEND, 24'd500);
      send_idle = 0;
      recv_idle = 0;
      queue_items(SECTION_ITEMS);
      wait_drain();

      if (errors == 0 && recv_count == predicted_count) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/tts_pkg.sv
rtl/core/tts_ctrl.sv
rtl/core/tts_dp.sv
rtl/core/tiltrotor_transition_sequencer_core.sv
verif/tiltrotor_transition_sequencer_core_test.sv
